@@ rtl/bfs_pkg.sv @@
// ---------------------------------------------------------------------------
// bfs_pkg
// Shared constants for the battery fault supervisor: register indexes,
// message source codes, limit reset values and result field positions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

  // number of timed message sources and width of a limit register
  localparam int NUM_SRC   = 6;
  localparam int LIMIT_W   = 16;
  localparam int SRC_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // width of the cell fault word and of the input tuser
  localparam int CELL_W    = 16;
  localparam int IN_USER_W = 1 + SRC_W;

  // result item: 11 flags, padded to two bytes
  localparam int RES_W      = 11;
  localparam int OUT_DATA_W = 16;

  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [SRC_W-1:0]   src_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // item kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_MESSAGE = 1'b1;

  // message sources, also the config register indexes of their limits
  localparam src_t SRC_CHARGER  = 3'd0;
  localparam src_t SRC_CURRENT  = 3'd1;
  localparam src_t SRC_TCS      = 3'd2;
  localparam src_t SRC_DRIVE    = 3'd3;
  localparam src_t SRC_DRIVE_V  = 3'd4;
  localparam src_t SRC_REQUEST  = 3'd5;

  // limit values after reset, indexed by source
  localparam limit_t LIMIT_RESET [NUM_SRC] = '{
    16'd400, 16'd1000, 16'd1000, 16'd300, 16'd1000, 16'd1000
  };

  // set where the reported flag means online, i.e. not timed out
  localparam logic [NUM_SRC-1:0] SRC_INVERTED = 6'b001101;

  // bit positions of the result fields in m_tdata
  localparam int RES_INTERLOCK     = 0;
  localparam int RES_IMD_ERROR     = 1;
  localparam int RES_RESET_PRESSED = 2;
  localparam int RES_CLEAR         = 3;
  localparam int RES_TIMEOUT_LO    = 4;
  localparam int RES_ERROR_STATE   = 10;

endpackage

`default_nettype wire

@@ rtl/battery_fault_supervisor.sv @@
// ---------------------------------------------------------------------------
// battery_fault_supervisor
// Pin debouncing, message timeout supervision and sticky error latch for a
// battery pack, one result item for every input item.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries input items. s_tuser[0] is the kind (0 tick, 1 message
//   stamp), s_tuser[3:1] the message source. A tick shifts the three pins
//   into their histories, recomputes the six timeout flags and updates the
//   error latch; a message stores now_ms as the arrival time of its source.
//   m_* carries one result item per input item with all eleven flags.
//   cfg_* writes the six 16-bit timeout limits, register i at index i;
//   indexes above five are dropped. cfg_ready is always high.
// Throughput and datapath:
//   the result of an item is registered in the output register when the item
//   is accepted. One item is taken every cycle while the receiver does not
//   stall; the whole update is one pass of subtract-compare and shift logic
//   between the input handshake and the output register.
// Reset and stalls:
//   rst clears histories, stamps and flags and loads the limit reset values.
//   When the receiver stalls, the output register holds its item and
//   s_tready stays low until that item is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module battery_fault_supervisor #(
  parameter int DEBOUNCE_LEN = 5,
  parameter int TIME_WIDTH   = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  // input items
  input  wire logic s_tvalid,
  output logic      s_tready,
  // tdata low to high: now_ms, interlock_pin, imd_pin, reset_pin,
  // cell_fault_word, zero fill
  input  wire logic [((TIME_WIDTH+3+bfs_pkg::CELL_W+7)/8)*8-1:0] s_tdata,
  // tuser low to high: kind, source
  input  wire logic [bfs_pkg::IN_USER_W-1:0] s_tuser,
  // result items
  output logic      m_tvalid,
  input  wire logic m_tready,
  // tdata low to high: interlock_closed, imd_error, reset_pressed,
  // clear_tables, charger_alive, current_outdated, tcs_alive,
  // drive_alive, drive_voltage_outdated, send_voltage_request,
  // error_state, zero fill
  output logic [bfs_pkg::OUT_DATA_W-1:0] m_tdata,
  // configuration writes
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [bfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bfs_pkg::*;

  localparam int PIN_LO = TIME_WIDTH;
  localparam int CELL_LO = TIME_WIDTH + 3;

  typedef logic [TIME_WIDTH-1:0]   time_t;
  typedef logic [DEBOUNCE_LEN-1:0] hist_t;

  // state
  limit_t limits [NUM_SRC];
  time_t  stamps [NUM_SRC];
  hist_t  interlock_history;
  hist_t  imd_history;
  hist_t  reset_history;
  logic   interlock_closed;
  logic   imd_error;
  logic   reset_pressed;
  logic   error_state;
  logic [NUM_SRC-1:0] timeout_flags;

  // next values
  hist_t  interlock_history_next;
  hist_t  imd_history_next;
  hist_t  reset_history_next;
  logic   interlock_closed_next;
  logic   imd_error_next;
  logic   reset_pressed_next;
  logic   error_state_next;
  logic   clear_next;
  logic [NUM_SRC-1:0] timeout_flags_next;
  logic [RES_W-1:0]   result_next;

  // input fields
  logic        in_kind;
  src_t        in_source;
  time_t       in_now;
  logic        in_interlock;
  logic        in_imd;
  logic        in_reset;
  logic [CELL_W-1:0] in_cell;

  logic accept;
  logic fault;
  logic c_on;
  logic t_on;
  logic d_on;

  assign in_kind      = s_tuser[0];
  assign in_source    = s_tuser[SRC_W:1];
  assign in_now       = s_tdata[TIME_WIDTH-1:0];
  assign in_interlock = s_tdata[PIN_LO];
  assign in_imd       = s_tdata[PIN_LO+1];
  assign in_reset     = s_tdata[PIN_LO+2];
  assign in_cell      = s_tdata[CELL_LO+CELL_W-1:CELL_LO];

  // output register frees up when empty or being taken
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // debounce, timeout compare and error latch for a tick
  always_comb begin
    interlock_history_next = {interlock_history[DEBOUNCE_LEN-2:0], in_interlock};
    imd_history_next       = {imd_history[DEBOUNCE_LEN-2:0], in_imd};
    reset_history_next     = {reset_history[DEBOUNCE_LEN-2:0], in_reset};

    interlock_closed_next = interlock_closed;
    if (&interlock_history_next) interlock_closed_next = 1'b1;
    else if (~|interlock_history_next) interlock_closed_next = 1'b0;

    // imd pin low means fault
    imd_error_next = imd_error;
    if (&imd_history_next) imd_error_next = 1'b0;
    else if (~|imd_history_next) imd_error_next = 1'b1;

    // reset pin low means pressed
    reset_pressed_next = reset_pressed;
    if (&reset_history_next) reset_pressed_next = 1'b0;
    else if (~|reset_history_next) reset_pressed_next = 1'b1;

    clear_next = ~|reset_history_next;

    // elapsed time per source, wrapping
    for (int i = 0; i < NUM_SRC; i++) begin
      timeout_flags_next[i] = ((in_now - stamps[i]) > TIME_WIDTH'(limits[i]))
                              ^ SRC_INVERTED[i];
    end

    c_on = timeout_flags_next[SRC_CHARGER];
    t_on = timeout_flags_next[SRC_TCS];
    d_on = timeout_flags_next[SRC_DRIVE];
    fault = (|in_cell) || imd_error_next || (d_on && c_on) || (!d_on && !c_on)
            || !t_on;

    error_state_next = error_state;
    if (fault) error_state_next = 1'b1;
    else if (reset_pressed_next) error_state_next = 1'b0;
  end

  // result item: fresh flags on a tick, stored flags on a message
  always_comb begin
    if (in_kind == KIND_TICK) begin
      result_next = {error_state_next, timeout_flags_next, clear_next,
                     reset_pressed_next, imd_error_next, interlock_closed_next};
    end else begin
      result_next = {error_state, timeout_flags, 1'b0,
                     reset_pressed, imd_error, interlock_closed};
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SRC; i++) limits[i] <= LIMIT_RESET[i];
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < NUM_SRC; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) limits[i] <= cfg_data;
      end
    end
  end

  // supervisor state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SRC; i++) stamps[i] <= '0;
      interlock_history <= '0;
      imd_history       <= '0;
      reset_history     <= '0;
      interlock_closed  <= 1'b0;
      imd_error         <= 1'b0;
      reset_pressed     <= 1'b0;
      error_state       <= 1'b0;
      timeout_flags     <= '0;
    end else if (accept) begin
      if (in_kind == KIND_MESSAGE) begin
        // sources six and seven store nothing
        for (int i = 0; i < NUM_SRC; i++) begin
          if (in_source == SRC_W'(i)) stamps[i] <= in_now;
        end
      end else begin
        interlock_history <= interlock_history_next;
        imd_history       <= imd_history_next;
        reset_history     <= reset_history_next;
        interlock_closed  <= interlock_closed_next;
        imd_error         <= imd_error_next;
        reset_pressed     <= reset_pressed_next;
        error_state       <= error_state_next;
        timeout_flags     <= timeout_flags_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_DATA_W'(result_next);
    end
  end

endmodule

`default_nettype wire

@@ rtl/bfs_checker.sv @@
// ---------------------------------------------------------------------------
// bfs_checker
// Port-level checks of the battery fault supervisor, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [bfs_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic cfg_ready
);

  import bfs_pkg::*;

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result item changed");

  // reset leaves the output empty
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an empty output register always takes an item
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

  // a clear pulse comes only with the debounced reset pressed
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[RES_CLEAR] |-> m_tdata[RES_RESET_PRESSED])
    else $error("clear pulse without debounced reset");

  // configuration is never refused
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind battery_fault_supervisor bfs_checker u_bfs_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

@@ tb/battery_fault_supervisor_tb.sv @@
// ---------------------------------------------------------------------------
// battery_fault_supervisor_tb
// Self-checking bench for the battery fault supervisor. A short directed
// table covers pin debouncing, the timeout edges, wrapping time, unused
// sources and cell fault extremes. Random traffic follows under several limit
// settings, including all-zero and all-ones limits. Every result item is
// compared field by field to table flags or a local model of the supervisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_fault_supervisor_tb;
  import bfs_pkg::*;

  localparam int DEB_LEN   = 5;
  localparam int TW        = 32;
  localparam int IN_DATA_W = ((TW + 3 + CELL_W + 7) / 8) * 8;
  localparam int RAND_PER_SETTING = 380;
  localparam int NUM_SETTINGS     = 5;
  localparam int WATCHDOG_LIMIT   = 2000;

  // source codes and register indexes that the block has no use for
  localparam src_t     SRC_UNUSED_LO = 3'd6;
  localparam src_t     SRC_UNUSED_HI = 3'd7;
  localparam cfg_idx_t CFG_SPARE_LO  = 3'd6;
  localparam cfg_idx_t CFG_SPARE_HI  = 3'd7;

  // first tick after reset: charger, tcs and drive online, error latched
  localparam logic [RES_W-1:0] FLAGS_FIRST_TICK = 11'h4D0;

  typedef struct packed {
    logic                kind;
    src_t                source;
    logic [TW-1:0]       now_ms;
    logic                interlock_pin;
    logic                imd_pin;
    logic                reset_pin;
    logic [CELL_W-1:0]   cell_word;
  } supv_item_t;

  typedef struct packed {
    supv_item_t          it;
    logic                typed;
    logic [RES_W-1:0]    flags;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  battery_fault_supervisor dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // supervisor model state
  logic [DEB_LEN-1:0] il_hist, imd_hist, rb_hist;
  logic [TW-1:0]      stamp_ms [NUM_SRC];
  limit_t             limit_ms [NUM_SRC];
  logic               interlock_q, imd_err_q, err_reset_q, err_latch_q;
  logic [NUM_SRC-1:0] tmo_q;

  logic [RES_W-1:0] flags_pending [$];
  dir_row_t         dir_table [$];

  string field_names [RES_W] = '{
    "interlock_closed", "imd_error", "reset_pressed", "clear_tables",
    "charger_alive", "current_outdated", "tcs_alive", "drive_alive",
    "drive_voltage_outdated", "send_voltage_request", "error_state"
  };

  // random traffic shaping
  logic [TW-1:0]      cur_now;
  logic               il_lvl, imd_lvl, rb_lvl;
  logic [NUM_SRC-1:0] src_mask;
  bit                 calm;
  int                 stall_left;
  int                 rx_n;

  int mism_count;
  int idle_cycles;
  int n_ticks, n_stamps, n_clear, n_release, n_settings;

  // next supervisor flags for one item, updates the model state
  function automatic logic [RES_W-1:0] supervise(supv_item_t it);
    logic [RES_W-1:0] r;
    logic [TW-1:0]    elapsed;
    logic             late, c_on, t_on, d_on, fault, clr, was_err;
    clr = 1'b0;
    if (it.kind == KIND_MESSAGE) begin
      if (it.source < NUM_SRC) stamp_ms[it.source] = it.now_ms;
    end else begin
      // debounce: flags move only on a uniform history
      il_hist = {il_hist[DEB_LEN-2:0], it.interlock_pin};
      if (&il_hist) interlock_q = 1'b1;
      else if (il_hist == '0) interlock_q = 1'b0;
      imd_hist = {imd_hist[DEB_LEN-2:0], it.imd_pin};
      if (&imd_hist) imd_err_q = 1'b0;
      else if (imd_hist == '0) imd_err_q = 1'b1;
      rb_hist = {rb_hist[DEB_LEN-2:0], it.reset_pin};
      if (&rb_hist) err_reset_q = 1'b0;
      else if (rb_hist == '0) err_reset_q = 1'b1;
      clr = (rb_hist == '0);

      // timeouts with wrapping elapsed time
      for (int i = 0; i < NUM_SRC; i++) begin
        elapsed  = it.now_ms - stamp_ms[i];
        late     = elapsed > TW'(limit_ms[i]);
        tmo_q[i] = SRC_INVERTED[i] ? !late : late;
      end

      // sticky error latch
      c_on    = tmo_q[SRC_CHARGER];
      t_on    = tmo_q[SRC_TCS];
      d_on    = tmo_q[SRC_DRIVE];
      was_err = err_latch_q;
      fault   = (it.cell_word != '0) || imd_err_q || (d_on == c_on) || !t_on;
      if (fault) err_latch_q = 1'b1;
      else if (err_reset_q) err_latch_q = 1'b0;
      if (was_err && !err_latch_q) n_release++;
      if (clr) n_clear++;
    end
    r = '0;
    r[RES_INTERLOCK]                  = interlock_q;
    r[RES_IMD_ERROR]                  = imd_err_q;
    r[RES_RESET_PRESSED]              = err_reset_q;
    r[RES_CLEAR]                      = clr;
    r[RES_TIMEOUT_LO +: NUM_SRC]      = tmo_q;
    r[RES_ERROR_STATE]                = err_latch_q;
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(supv_item_t it);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[TW-1:0]             = it.now_ms;
    d[TW]                 = it.interlock_pin;
    d[TW+1]               = it.imd_pin;
    d[TW+2]               = it.reset_pin;
    d[TW+3 +: CELL_W]     = it.cell_word;
    return d;
  endfunction

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_row(logic kind, src_t src, logic [TW-1:0] now_ms,
                                  logic il, logic imd, logic rb,
                                  logic [CELL_W-1:0] cell_bits, logic typed,
                                  logic [RES_W-1:0] flags);
    dir_row_t row;
    row.it.kind          = kind;
    row.it.source        = src;
    row.it.now_ms        = now_ms;
    row.it.interlock_pin = il;
    row.it.imd_pin       = imd;
    row.it.reset_pin     = rb;
    row.it.cell_word     = cell_bits;
    row.typed            = typed;
    row.flags            = flags;
    dir_table.push_back(row);
  endfunction

  // random item: time mostly advances, pins hold levels with some glitches
  function automatic supv_item_t next_random_item();
    supv_item_t it;
    int         r;
    src_t       s;
    r = $urandom_range(0, 99);
    if (r < 15) cur_now = cur_now;
    else if (r < 88) cur_now = cur_now + $urandom_range(1, 40);
    else if (r < 95) cur_now = cur_now + $urandom_range(41, 1500);
    else if (r < 98) cur_now = cur_now + $urandom_range(1500, 70000);
    else cur_now = $urandom;
    it.now_ms = cur_now;
    it.kind   = ($urandom_range(0, 99) < 30) ? KIND_MESSAGE : KIND_TICK;
    if ($urandom_range(0, 19) == 0) begin
      s = src_t'($urandom_range(SRC_UNUSED_LO, SRC_UNUSED_HI));
    end else begin
      do s = src_t'($urandom_range(0, NUM_SRC - 1)); while (!src_mask[s]);
    end
    it.source = s;
    if ($urandom_range(0, 99) < 6) il_lvl = ~il_lvl;
    if ($urandom_range(0, 99) < 4) imd_lvl = ~imd_lvl;
    if ($urandom_range(0, 99) < 5) rb_lvl = ~rb_lvl;
    it.interlock_pin = ($urandom_range(0, 99) < 8) ? 1'($urandom_range(0, 1)) : il_lvl;
    it.imd_pin       = ($urandom_range(0, 99) < 8) ? 1'($urandom_range(0, 1)) : imd_lvl;
    it.reset_pin     = ($urandom_range(0, 99) < 8) ? 1'($urandom_range(0, 1)) : rb_lvl;
    r = $urandom_range(0, 99);
    if (r < 85) it.cell_word = '0;
    else if (r < 93) it.cell_word = CELL_W'(1) << $urandom_range(0, CELL_W - 1);
    else it.cell_word = CELL_W'($urandom_range(0, 16'hFFFF));
    return it;
  endfunction

  task automatic send_item(supv_item_t it, logic typed, logic [RES_W-1:0] flags);
    int               gap;
    logic [RES_W-1:0] pred;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_item(it);
    s_tuser  <= {it.source, it.kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = supervise(it);
    flags_pending.push_back(typed ? flags : pred);
    if (it.kind == KIND_MESSAGE) n_stamps++;
    else n_ticks++;
  endtask

  task automatic write_limit(cfg_idx_t idx, limit_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_SRC) limit_ms[idx] = val;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (flags_pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic exp_v, logic act_v);
    mism_count++;
    if (mism_count <= 10)
      $display("mismatch %0d on %s: expected %0b, got %0b", mism_count, what, exp_v,
               act_v);
  endtask

  // result checker
  always @(posedge clk) begin
    logic [RES_W-1:0] exp_flags;
    if (!rst && m_tvalid && m_tready) begin
      if (flags_pending.size() == 0) begin
        mism_count++;
        if (mism_count <= 10)
          $display("mismatch %0d: result item %h with nothing pending", mism_count,
                   m_tdata);
      end else begin
        exp_flags = flags_pending.pop_front();
        for (int f = 0; f < RES_W; f++)
          if (exp_flags[f] !== m_tdata[f])
            report_mismatch(field_names[f], exp_flags[f], m_tdata[f]);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rx_n = pick_gap();
      if (rx_n > 0) begin
        m_tready   <= 1'b0;
        stall_left <= rx_n - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    supv_item_t it;
    stall_left = 0;
    idle_cycles = 0;
    mism_count = 0;
    n_ticks = 0;
    n_stamps = 0;
    n_clear = 0;
    n_release = 0;
    n_settings = 1;
    calm = 1'b0;
    il_hist = '0;
    imd_hist = '0;
    rb_hist = '0;
    interlock_q = 1'b0;
    imd_err_q = 1'b0;
    err_reset_q = 1'b0;
    err_latch_q = 1'b0;
    tmo_q = '0;
    for (int i = 0; i < NUM_SRC; i++) begin
      stamp_ms[i] = '0;
      limit_ms[i] = LIMIT_RESET[i];
    end
    cur_now = '0;
    il_lvl = 1'b1;
    imd_lvl = 1'b1;
    rb_lvl = 1'b1;
    src_mask = '1;

    // directed table, limits at reset values
    add_row(KIND_TICK, SRC_CHARGER, 32'd0, 1, 1, 1, 16'h0000, 1, FLAGS_FIRST_TICK);
    add_row(KIND_MESSAGE, SRC_UNUSED_LO, 32'd123, 0, 0, 0, 16'h0000, 1,
            FLAGS_FIRST_TICK);
    add_row(KIND_MESSAGE, SRC_UNUSED_HI, 32'd5, 1, 1, 1, 16'hFFFF, 1,
            FLAGS_FIRST_TICK);
    // fill the histories with ones
    for (int i = 1; i <= 4; i++)
      add_row(KIND_TICK, SRC_CHARGER, i, 1, 1, 1, 16'h0000, 0, '0);
    // mixed history keeps the flags
    add_row(KIND_TICK, SRC_CHARGER, 32'd5, 0, 0, 0, 16'h0000, 0, '0);
    add_row(KIND_MESSAGE, SRC_CHARGER, 32'd1000, 0, 0, 0, 16'h0000, 0, '0);
    add_row(KIND_MESSAGE, SRC_TCS, 32'd1000, 0, 0, 0, 16'h0000, 0, '0);
    add_row(KIND_MESSAGE, SRC_CURRENT, 32'd1000, 0, 0, 0, 16'h0000, 0, '0);
    // elapsed equal to the limit, then one past it
    add_row(KIND_TICK, SRC_CHARGER, 32'd1400, 0, 0, 0, 16'h0000, 0, '0);
    add_row(KIND_TICK, SRC_CHARGER, 32'd1401, 0, 0, 0, 16'h0000, 0, '0);
    // five low samples: imd fault, reset held and clear pulse
    add_row(KIND_TICK, SRC_CHARGER, 32'd1402, 0, 0, 0, 16'h0000, 0, '0);
    add_row(KIND_TICK, SRC_CHARGER, 32'd1403, 0, 0, 0, 16'h0000, 0, '0);
    add_row(KIND_TICK, SRC_CHARGER, 32'd1404, 1, 1, 0, 16'hFFFF, 0, '0);
    // stamps just before the time wraps
    add_row(KIND_MESSAGE, SRC_DRIVE, 32'hFFFF_FF00, 0, 0, 0, 16'h0000, 0, '0);
    add_row(KIND_MESSAGE, SRC_DRIVE_V, 32'hFFFF_FF00, 0, 0, 0, 16'h0000, 0, '0);
    add_row(KIND_MESSAGE, SRC_REQUEST, 32'hFFFF_FF00, 0, 0, 0, 16'h0000, 0, '0);
    add_row(KIND_TICK, SRC_CHARGER, 32'h0000_002C, 1, 1, 1, 16'h8000, 0, '0);
    add_row(KIND_TICK, SRC_CHARGER, 32'h0000_002D, 1, 1, 1, 16'h0001, 0, '0);
    add_row(KIND_TICK, SRC_CHARGER, 32'hFFFF_FFFF, 1, 1, 1, 16'h0000, 0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i])
      send_item(dir_table[i].it, dir_table[i].typed, dir_table[i].flags);

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      // new limits only once the block has gone quiet
      if (ph > 0) begin
        wait_drained();
        n_settings++;
        for (int i = 0; i < NUM_SRC; i++) begin
          case (ph)
            1: write_limit(cfg_idx_t'(i), 16'h0000);
            2: write_limit(cfg_idx_t'(i), 16'hFFFF);
            3: write_limit(cfg_idx_t'(i), limit_t'($urandom_range(0, 1200)));
            default: write_limit(cfg_idx_t'(i), limit_t'($urandom_range(0, 16'hFFFF)));
          endcase
        end
        if (ph == 3) begin
          write_limit(CFG_SPARE_LO, limit_t'($urandom_range(0, 16'hFFFF)));
          write_limit(CFG_SPARE_HI, limit_t'($urandom_range(0, 16'hFFFF)));
        end
        cfg_valid <= 1'b0;
      end
      for (int k = 0; k < RAND_PER_SETTING; k++) begin
        // new scenario every 50 items: which sources talk, idling or not
        if (k % 50 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
          src_mask = ($urandom_range(0, 3) == 0) ? '1 : NUM_SRC'($urandom_range(1, 63));
        end
        it = next_random_item();
        send_item(it, 1'b0, '0);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (5) @(posedge clk);
    $display("sent %0d ticks and %0d stamps under %0d limit settings", n_ticks,
             n_stamps, n_settings);
    $display("saw %0d clear pulses and %0d error latch releases", n_clear, n_release);
    if (mism_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bfs_pkg.sv
rtl/battery_fault_supervisor.sv
rtl/bfs_checker.sv
tb/battery_fault_supervisor_tb.sv
